// File: sv/kole_pkg.sv
// Package: widths, codes and shared types of the keyed ordered list engine.
`default_nettype none

package kole_pkg;

    localparam int LIST_DEPTH_DEF = 32;

    localparam int OPC_W  = 2;
    localparam int KEY_W  = 10;
    localparam int PAY_W  = 32;
    localparam int STS_W  = 2;
    localparam int SIZE_W = 6;

    localparam logic [OPC_W-1:0] OP_INSERT     = 2'd0;
    localparam logic [OPC_W-1:0] OP_REMOVE     = 2'd1;
    localparam logic [OPC_W-1:0] OP_MOVE_FRONT = 2'd2;
    localparam logic [OPC_W-1:0] OP_EXISTS     = 2'd3;

    localparam logic [STS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STS_W-1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } entry_t;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic             scan;
        logic             ins;
        logic             rem;
        logic             mtf;
        entry_t           req;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// File: sv/kole_ifs.sv
// Interfaces: request and response channels of the keyed ordered list engine.
`default_nettype none

interface kole_req_if
    import kole_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [OPC_W-1:0] opcode;
    logic [KEY_W-1:0] entry_key;
    logic [PAY_W-1:0] entry_payload;

    modport source (output valid, opcode, entry_key, entry_payload, input ready);
    modport sink   (input valid, opcode, entry_key, entry_payload, output ready);
endinterface

interface kole_rsp_if
    import kole_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [STS_W-1:0]  status;
    logic              found;
    logic [PAY_W-1:0]  removed_payload;
    logic [SIZE_W-1:0] list_size;
    logic [KEY_W-1:0]  head_key;

    modport source (output valid, status, found, removed_payload, list_size, head_key,
                    input ready);
    modport sink   (input valid, status, found, removed_payload, list_size, head_key,
                    output ready);
endinterface

`default_nettype wire

// File: sv/kole_cell.sv
// List cell: one slot plus the match prefix and first-hit carry of the search chain.
`default_nettype none

module kole_cell
    import kole_pkg::*;
(
    input  wire logic       clk,
    input  wire cell_ctrl_t ctrl,
    input  wire logic       occupied,
    input  wire logic       ins_here,
    input  wire logic       prefix_in,
    input  wire entry_t     carry_in,
    input  wire entry_t     left_entry,
    input  wire entry_t     right_entry,
    output entry_t          entry,
    output logic            prefix,
    output entry_t          carry
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   prefix_reg;
    logic   prefix_next;
    entry_t carry_reg;
    entry_t carry_next;
    logic   match;

    always_comb
    begin
        match       = occupied && (entry_reg.key == ctrl.req.key);
        prefix_next = prefix_in | match;
        carry_next  = prefix_in ? carry_in : entry_reg;
    end

    // remove: slots from the hit onward pull from the right
    // move to front: slots up to the hit pull from the left
    always_comb
    begin
        priority if (ctrl.ins && ins_here)
        begin
            entry_next = ctrl.req;
        end
        else if (ctrl.rem && prefix_reg)
        begin
            entry_next = right_entry;
        end
        else if (ctrl.mtf && !prefix_in)
        begin
            entry_next = left_entry;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        if (ctrl.scan)
        begin
            prefix_reg <= prefix_next;
            carry_reg  <= carry_next;
        end
    end

    assign entry  = entry_reg;
    assign prefix = prefix_reg;
    assign carry  = carry_reg;

endmodule

`default_nettype wire

// File: sv/keyed_ordered_list_engine.sv
// Top level: keyed ordered list engine, a chain of list cells under a small sequencer.
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+-----------------------------------------------------
//  req     | in  | valid / ready | opcode, entry_key, entry_payload
//  rsp     | out | valid / ready | status, found, removed_payload, list_size, head_key
//
// A request is accepted, then the match prefix and first-hit carry ripple down the cell
// chain in the scan state, then the update state applies the result.
// rst_n clears the sequencer, entry count and response valid; slots hold no reset.
// The update cycle waits while a previous response is still held on rsp.
`default_nettype none

module keyed_ordered_list_engine
    import kole_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    kole_req_if.sink   req,
    kole_rsp_if.source rsp
);

    localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
    localparam int STEP_W = $clog2(LIST_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_APPLY = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [OPC_W-1:0]    op_reg;
    entry_t              req_reg;

    logic                out_valid_reg, out_valid_next;
    logic [STS_W-1:0]    status_reg, status_next;
    logic                found_reg, found_next;
    logic [PAY_W-1:0]    removed_reg, removed_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic [KEY_W-1:0]    head_reg, head_next;

    cell_ctrl_t          ctrl;
    entry_t              entry_q  [LIST_DEPTH];
    entry_t              carry_q  [LIST_DEPTH];
    logic                prefix_q [LIST_DEPTH];

    logic                req_fire;
    logic                apply_go;
    logic                hit;
    logic                full;
    logic                empty;
    logic                op_ok;

    assign req_fire = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);

    assign hit      = prefix_q[LIST_DEPTH-1];
    assign full     = (count_reg == CNT_W'(LIST_DEPTH));
    assign empty    = (count_reg == '0);
    assign apply_go = (state_reg == S_APPLY) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        if (op_reg == OP_INSERT)
        begin
            status_next = full ? ST_FULL : ST_OK;
        end
        else if (empty)
        begin
            status_next = ST_EMPTY;
        end
        else if (!hit)
        begin
            status_next = ST_NOT_FOUND;
        end
        else
        begin
            status_next = ST_OK;
        end
        op_ok = (status_next == ST_OK);
    end

    always_comb
    begin
        ctrl.scan = (state_reg == S_SCAN);
        ctrl.ins  = apply_go && op_ok && (op_reg == OP_INSERT);
        ctrl.rem  = apply_go && op_ok && (op_reg == OP_REMOVE);
        ctrl.mtf  = apply_go && op_ok && (op_reg == OP_MOVE_FRONT);
        ctrl.req  = req_reg;
    end

    genvar gi;
    generate
        for (gi = 0; gi < LIST_DEPTH; gi++)
        begin : g_cell
            logic   pin;
            entry_t cin;
            entry_t lin;
            entry_t rin;

            if (gi == 0)
            begin : g_first
                assign pin = 1'b0;
                assign cin = entry_q[0];
                assign lin = carry_q[LIST_DEPTH-1];
            end
            else
            begin : g_rest
                assign pin = prefix_q[gi-1];
                assign cin = carry_q[gi-1];
                assign lin = entry_q[gi-1];
            end

            if (gi == LIST_DEPTH - 1)
            begin : g_last
                assign rin = entry_q[gi];
            end
            else
            begin : g_mid
                assign rin = entry_q[gi+1];
            end

            kole_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .occupied    (CNT_W'(gi) < count_reg),
                .ins_here    (CNT_W'(gi) == count_reg),
                .prefix_in   (pin),
                .carry_in    (cin),
                .left_entry  (lin),
                .right_entry (rin),
                .entry       (entry_q[gi]),
                .prefix      (prefix_q[gi]),
                .carry       (carry_q[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        found_next     = hit;
        removed_next   = '0;
        size_next      = size_reg;
        head_next      = head_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = S_SCAN;
                    step_next  = '0;
                end
            end
            S_SCAN:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(LIST_DEPTH - 1))
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                if (apply_go)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    if (ctrl.ins)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    else if (ctrl.rem)
                    begin
                        count_next   = count_reg - 1'b1;
                        removed_next = carry_q[LIST_DEPTH-1].payload;
                    end
                    size_next = SIZE_W'(count_next);

                    priority if (count_next == '0)
                    begin
                        head_next = '0;
                    end
                    else if (ctrl.ins && empty)
                    begin
                        head_next = req_reg.key;
                    end
                    else if (ctrl.rem && prefix_q[0])
                    begin
                        head_next = entry_q[1].key;
                    end
                    else if (ctrl.mtf)
                    begin
                        head_next = carry_q[LIST_DEPTH-1].key;
                    end
                    else
                    begin
                        head_next = entry_q[0].key;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            op_reg          <= req.opcode;
            req_reg.key     <= req.entry_key;
            req_reg.payload <= req.entry_payload;
        end
        if (apply_go)
        begin
            status_reg  <= status_next;
            found_reg   <= found_next;
            removed_reg <= removed_next;
            size_reg    <= size_next;
            head_reg    <= head_next;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = status_reg;
    assign rsp.found           = found_reg;
    assign rsp.removed_payload = removed_reg;
    assign rsp.list_size       = size_reg;
    assign rsp.head_key        = head_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(LIST_DEPTH))
        else $error("entry count beyond list depth");

    a_req_to_scan: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> (state_reg == S_SCAN))
        else $error("accepted request did not start the search");

    a_rsp_from_apply: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg && out_valid_next) |-> (state_reg == S_APPLY))
        else $error("response raised outside the update cycle");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_APPLY) |=> $stable(count_reg))
        else $error("entry count changed outside the update cycle");

endmodule

`default_nettype wire
